>>> rtl/core/axis_rotate_and_plot_point_top_assert.svh
// assertion macros for the point rotation block and its port checker
// expects signals named clock and reset in the scope of each use
`ifndef AXIS_ROTATE_AND_PLOT_POINT_TOP_ASSERT_SVH
`define AXIS_ROTATE_AND_PLOT_POINT_TOP_ASSERT_SVH

// same-cycle implication
`define ARP_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define ARP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/core/arp_pkg.sv
// shared types and constants for the point rotation and plot block
// no dependencies
package arp_pkg;

   localparam int COORD_W = 16;
   localparam int CFG_W   = 16;

   // register indexes on the csr port
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_AXIS_X    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_AXIS_Y    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_AXIS_Z    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_COS_ANGLE = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SIN_ANGLE = 3'd4;

   // pipeline depth: five datapath stages plus the output register
   localparam int PIPE_DEPTH = 6;

   // rotation datapath widths
   localparam int PROD_W  = 32;
   localparam int DOT_W   = 34;
   localparam int CROSS_W = 33;
   localparam int ND_W    = 50;
   localparam int T2_W    = 49;
   localparam int OMC_W   = 18;
   localparam int T3_W    = 68;
   localparam int SUM_W   = 52;
   localparam int RND_W   = 22;

   localparam int ONE_Q15     = 32768;
   localparam int T1_SHIFT    = 15;
   localparam int T3_SHIFT    = 15;
   localparam int ROUND_SHIFT = 30;
   localparam int ROUND_BIAS  = 1 << (ROUND_SHIFT - 1);
   localparam int COORD_MAX   = 32767;
   localparam int COORD_MIN   = -32768;

   // screen geometry
   localparam int WORDS_PER_LINE  = 50;
   localparam int SCREEN_LINES    = 600;
   localparam int PIXELS_PER_WORD = 16;
   localparam int PIX_SHIFT       = 4;
   localparam int SCREEN_WIDTH    = PIXELS_PER_WORD * WORDS_PER_LINE;
   localparam int X_OFFSET        = 400;
   localparam int Y_OFFSET        = 300;

   // projection widths and scale
   localparam int PROJ_W      = 18;
   localparam int SCR_W       = 14;
   localparam int X_DIV_SHIFT = 9;
   localparam int Y_DIV_SHIFT = 7;
   localparam int X_BIAS      = (1 << X_DIV_SHIFT) - 1;
   localparam int Y_BIAS      = (1 << Y_DIV_SHIFT) - 1;
   localparam int WORD_FULL_W = 24;
   localparam int WORD_W      = 15;
   localparam int MASK_W      = 16;
   localparam logic [MASK_W-1:0] MASK_MSB = 16'h8000;

   typedef struct packed {
      logic signed [COORD_W-1:0] point_x;
      logic signed [COORD_W-1:0] point_y;
      logic signed [COORD_W-1:0] point_z;
   } arp_req_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] rotated_x;
      logic signed [COORD_W-1:0] rotated_y;
      logic signed [COORD_W-1:0] rotated_z;
      logic        [WORD_W-1:0]  pixel_word;
      logic        [MASK_W-1:0]  pixel_mask;
      logic                      on_screen;
   } arp_rsp_type;

   typedef struct packed {
      logic signed [CFG_W-1:0] axis_x;
      logic signed [CFG_W-1:0] axis_y;
      logic signed [CFG_W-1:0] axis_z;
      logic signed [CFG_W-1:0] cos_angle;
      logic signed [CFG_W-1:0] sin_angle;
   } arp_cfg_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] z;
   } arp_vec_type;

   typedef struct packed {
      logic [WORD_W-1:0] pixel_word;
      logic [MASK_W-1:0] pixel_mask;
      logic              on_screen;
   } arp_pix_type;

   // stage load strobes for the rotation datapath
   typedef struct packed {
      logic s1;
      logic s2;
      logic s3;
      logic s4;
      logic s5;
   } arp_adv_type;

   localparam arp_cfg_type CFG_RESET = '{
      axis_x:    16'sd10922,
      axis_y:    16'sd21845,
      axis_z:    16'sd21845,
      cos_angle: 16'sd32766,
      sin_angle: 16'sd328
   };

endpackage

>>> rtl/core/axis_rotate_and_plot_point_top.sv
// point rotation about a configured axis with framebuffer projection
// 6 register stages (five datapath + output); rsp_valid flags the output register's item
// one item per cycle unless results stall; multiplier chain fully pipelined, per-stage valids
// req_ready drops only when every stage holds an item and the result is not taken
// reset (sync, active high) empties the pipeline and loads the axis/angle reset values
module axis_rotate_and_plot_point_top (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  arp_pkg::arp_req_type            req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output arp_pkg::arp_rsp_type            rsp_data,
   input  logic                            csr_we,
   input  logic [arp_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [arp_pkg::CFG_W-1:0]       csr_wdata
);
   import arp_pkg::*;

   arp_cfg_type cfg_ff, cfg_in;
   logic [PIPE_DEPTH-1:0] valid_ff, valid_in, stage_ready, stage_load;
   arp_adv_type adv;
   arp_vec_type rot;
   arp_pix_type pix;
   arp_rsp_type rsp_ff, rsp_in;

   // configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_AXIS_X:    cfg_in.axis_x    = csr_wdata;
            CSR_AXIS_Y:    cfg_in.axis_y    = csr_wdata;
            CSR_AXIS_Z:    cfg_in.axis_z    = csr_wdata;
            CSR_COS_ANGLE: cfg_in.cos_angle = csr_wdata;
            CSR_SIN_ANGLE: cfg_in.sin_angle = csr_wdata;
            default: ;
         endcase
      end
   end

   // a stage takes a new item when it is empty or its item moves on
   always_comb begin
      stage_ready[PIPE_DEPTH-1] = !valid_ff[PIPE_DEPTH-1] || rsp_ready;
      for (int k = PIPE_DEPTH - 2; k >= 0; k--) begin
         stage_ready[k] = !valid_ff[k] || stage_ready[k+1];
      end
      stage_load[0] = req_valid && stage_ready[0];
      valid_in[0]   = stage_ready[0] ? req_valid : valid_ff[0];
      for (int k = 1; k < PIPE_DEPTH; k++) begin
         stage_load[k] = valid_ff[k-1] && stage_ready[k];
         valid_in[k]   = stage_ready[k] ? valid_ff[k-1] : valid_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff   <= CFG_RESET;
         valid_ff <= '0;
      end else begin
         cfg_ff   <= cfg_in;
         valid_ff <= valid_in;
      end
   end

   assign adv.s1 = stage_load[0];
   assign adv.s2 = stage_load[1];
   assign adv.s3 = stage_load[2];
   assign adv.s4 = stage_load[3];
   assign adv.s5 = stage_load[4];

   arp_rotate u_rotate (
      .clock    (clock),
      .cfg      (cfg_ff),
      .req_data (req_data),
      .adv      (adv),
      .rot      (rot)
   );

   arp_project u_project (
      .rot (rot),
      .pix (pix)
   );

   always_comb begin
      rsp_in.rotated_x  = rot.x;
      rsp_in.rotated_y  = rot.y;
      rsp_in.rotated_z  = rot.z;
      rsp_in.pixel_word = pix.pixel_word;
      rsp_in.pixel_mask = pix.pixel_mask;
      rsp_in.on_screen  = pix.on_screen;
   end

   // output register
   always_ff @(posedge clock) begin
      if (stage_load[PIPE_DEPTH-1]) begin
         rsp_ff <= rsp_in;
      end
   end

   assign req_ready = stage_ready[0];
   assign rsp_valid = valid_ff[PIPE_DEPTH-1];
   assign rsp_data  = rsp_ff;

endmodule

>>> rtl/core/arp_rotate.sv
// five-stage rodrigues rotation datapath, Q8.8 point by Q1.15 axis and angle
// depends on arp_pkg; stage loads come from the top level control
module arp_rotate (
   input  logic                 clock,
   input  arp_pkg::arp_cfg_type cfg,
   input  arp_pkg::arp_req_type req_data,
   input  arp_pkg::arp_adv_type adv,
   output arp_pkg::arp_vec_type rot
);
   import arp_pkg::*;

   logic signed [COORD_W-1:0] v [3];
   logic signed [CFG_W-1:0]   n [3];
   logic signed [CFG_W-1:0]   cos_s;
   logic signed [CFG_W-1:0]   sin_s;
   logic signed [OMC_W-1:0]   omc;

   // stage 1: all 16x16 products
   logic signed [PROD_W-1:0] dotp_in [3], dotp_ff [3];
   logic signed [PROD_W-1:0] crsa_in [3], crsa_ff [3];
   logic signed [PROD_W-1:0] crsb_in [3], crsb_ff [3];
   logic signed [PROD_W-1:0] t1a_in  [3], t1a_ff  [3];
   // stage 2: dot and cross sums
   logic signed [DOT_W-1:0]   dot_in, dot_ff;
   logic signed [CROSS_W-1:0] crs_in [3], crs_ff [3];
   logic signed [PROD_W-1:0]  t1b_ff [3];
   // stage 3: n*dot and cross*sin
   logic signed [ND_W-1:0]   nd_in  [3], nd_ff  [3];
   logic signed [T2_W-1:0]   t2c_in [3], t2c_ff [3];
   logic signed [PROD_W-1:0] t1c_ff [3];
   // stage 4: times (1 - cos)
   logic signed [T3_W-1:0]   t3_in  [3], t3_ff  [3];
   logic signed [T2_W-1:0]   t2d_ff [3];
   logic signed [PROD_W-1:0] t1d_ff [3];
   // stage 5: sum, round, saturate
   logic signed [SUM_W-1:0]   sum    [3];
   logic signed [RND_W-1:0]   rnd    [3];
   logic signed [COORD_W-1:0] rot_in [3], rot_ff [3];

   function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [RND_W-1:0] r);
      logic signed [COORD_W-1:0] s;
      priority if (r > RND_W'(COORD_MAX)) begin
         s = COORD_W'(COORD_MAX);
      end else if (r < RND_W'(COORD_MIN)) begin
         s = COORD_W'(COORD_MIN);
      end else begin
         s = r[COORD_W-1:0];
      end
      return s;
   endfunction

   assign v[0]  = req_data.point_x;
   assign v[1]  = req_data.point_y;
   assign v[2]  = req_data.point_z;
   assign n[0]  = cfg.axis_x;
   assign n[1]  = cfg.axis_y;
   assign n[2]  = cfg.axis_z;
   assign cos_s = cfg.cos_angle;
   assign sin_s = cfg.sin_angle;
   assign omc   = OMC_W'(ONE_Q15) - OMC_W'(cos_s);

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         dotp_in[i] = PROD_W'(n[i]) * PROD_W'(v[i]);
         t1a_in[i]  = PROD_W'(v[i]) * PROD_W'(cos_s);
      end
      // cross product n x v as two product columns
      crsa_in[0] = PROD_W'(n[1]) * PROD_W'(v[2]);
      crsb_in[0] = PROD_W'(n[2]) * PROD_W'(v[1]);
      crsa_in[1] = PROD_W'(n[2]) * PROD_W'(v[0]);
      crsb_in[1] = PROD_W'(n[0]) * PROD_W'(v[2]);
      crsa_in[2] = PROD_W'(n[0]) * PROD_W'(v[1]);
      crsb_in[2] = PROD_W'(n[1]) * PROD_W'(v[0]);
   end

   always_comb begin
      dot_in = DOT_W'(dotp_ff[0]) + DOT_W'(dotp_ff[1]) + DOT_W'(dotp_ff[2]);
      for (int i = 0; i < 3; i++) begin
         crs_in[i] = CROSS_W'(crsa_ff[i]) - CROSS_W'(crsb_ff[i]);
         nd_in[i]  = ND_W'(n[i]) * ND_W'(dot_ff);
         t2c_in[i] = T2_W'(crs_ff[i]) * T2_W'(sin_s);
         t3_in[i]  = T3_W'(nd_ff[i]) * T3_W'(omc);
         // floor shifts of signed values are arithmetic shifts
         sum[i]    = (SUM_W'(t1d_ff[i]) <<< T1_SHIFT) + SUM_W'(t2d_ff[i])
                   + SUM_W'(t3_ff[i] >>> T3_SHIFT) + SUM_W'(ROUND_BIAS);
         rnd[i]    = RND_W'(sum[i] >>> ROUND_SHIFT);
         rot_in[i] = sat_coord(rnd[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (adv.s1) begin
         for (int i = 0; i < 3; i++) begin
            dotp_ff[i] <= dotp_in[i];
            crsa_ff[i] <= crsa_in[i];
            crsb_ff[i] <= crsb_in[i];
            t1a_ff[i]  <= t1a_in[i];
         end
      end
      if (adv.s2) begin
         dot_ff <= dot_in;
         for (int i = 0; i < 3; i++) begin
            crs_ff[i] <= crs_in[i];
            t1b_ff[i] <= t1a_ff[i];
         end
      end
      if (adv.s3) begin
         for (int i = 0; i < 3; i++) begin
            nd_ff[i]  <= nd_in[i];
            t2c_ff[i] <= t2c_in[i];
            t1c_ff[i] <= t1b_ff[i];
         end
      end
      if (adv.s4) begin
         for (int i = 0; i < 3; i++) begin
            t3_ff[i]  <= t3_in[i];
            t2d_ff[i] <= t2c_ff[i];
            t1d_ff[i] <= t1c_ff[i];
         end
      end
      if (adv.s5) begin
         for (int i = 0; i < 3; i++) begin
            rot_ff[i] <= rot_in[i];
         end
      end
   end

   assign rot.x = rot_ff[0];
   assign rot.y = rot_ff[1];
   assign rot.z = rot_ff[2];

endmodule

>>> rtl/core/arp_project.sv
// screen projection of a rotated point: word index, bit mask, on-screen flag
// depends on arp_pkg; pure logic, registered by the top level
module arp_project (
   input  arp_pkg::arp_vec_type rot,
   output arp_pkg::arp_pix_type pix
);
   import arp_pkg::*;

   logic signed [PROJ_W-1:0] x3, xb, xs, qx;
   logic signed [PROJ_W-1:0] y1, yb, ys, qy;
   logic signed [SCR_W-1:0]  px, py;
   logic [WORD_FULL_W-1:0]   word_full;
   logic                     on;

   always_comb begin
      // 1.5 * x in real units is 3x / 512, truncated toward zero
      x3 = (PROJ_W'(rot.x) <<< 1) + PROJ_W'(rot.x);
      xb = x3[PROJ_W-1] ? PROJ_W'(X_BIAS) : PROJ_W'(0);
      xs = x3 + xb;
      qx = xs >>> X_DIV_SHIFT;
      // 2 * y in real units is y / 128
      y1 = PROJ_W'(rot.y);
      yb = y1[PROJ_W-1] ? PROJ_W'(Y_BIAS) : PROJ_W'(0);
      ys = y1 + yb;
      qy = ys >>> Y_DIV_SHIFT;

      px = SCR_W'(qx) + SCR_W'(X_OFFSET);
      py = SCR_W'(qy) + SCR_W'(Y_OFFSET);

      on = !px[SCR_W-1] && (int'(px) < SCREEN_WIDTH) &&
           !py[SCR_W-1] && (int'(py) < SCREEN_LINES);

      word_full = WORD_FULL_W'(px[SCR_W-2:PIX_SHIFT])
                + WORD_FULL_W'(py[SCR_W-2:0]) * WORD_FULL_W'(WORDS_PER_LINE);

      pix.on_screen  = on;
      pix.pixel_word = on ? word_full[WORD_W-1:0] : '0;
      pix.pixel_mask = on ? (MASK_MSB >> px[PIX_SHIFT-1:0]) : '0;
   end

endmodule

>>> rtl/core/arp_checker.sv
// port-level checker for the point rotation block, bound to the top level
// depends on arp_pkg and the assertion macro header
`include "axis_rotate_and_plot_point_top_assert.svh"

module arp_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input arp_pkg::arp_rsp_type rsp_data
);
   import arp_pkg::*;

   // a stalled result stays put
   `ARP_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "result item changed or dropped while stalled")
   // off-screen results carry no pixel
   `ARP_ASSERT_NOW(a_off_screen_zero, rsp_valid && !rsp_data.on_screen, (rsp_data.pixel_word == '0) && (rsp_data.pixel_mask == '0), "off-screen item with nonzero word or mask")
   `ARP_ASSERT_NOW(a_mask_onehot, rsp_valid && rsp_data.on_screen, $onehot(rsp_data.pixel_mask), "on-screen item without a one-hot mask")
   // input backs up only when the whole pipeline is full and the output is stalled
   `ARP_ASSERT_NOW(a_full_stall, !req_ready, rsp_valid && !rsp_ready, "input stalled while the output is free")

endmodule

bind axis_rotate_and_plot_point_top arp_checker u_checker (.*);

>>> tb/tb_top.sv
// self-checking testbench for axis_rotate_and_plot_point_top: rodrigues rotation and pixel plot
// depends on arp_pkg and the rtl top level; streams points under random back-pressure
// and compares every result against an in-line fixed-point predictor
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import arp_pkg::*;

   localparam int RESET_CYCLES    = 11;
   localparam int RAND_PHASES     = 8;
   localparam int ITEMS_PER_PHASE = 195;
   localparam int MAX_REPORTS     = 40;
   localparam int TIMEOUT_NS      = 1000000;

   logic                 clock     = 1'b0;
   logic                 reset     = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   arp_req_type          req_data  = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   arp_rsp_type          rsp_data;
   logic                 csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CFG_W-1:0]     csr_wdata = '0;

   arp_req_type points_pending[$];
   arp_rsp_type plots_due[$];
   arp_cfg_type rotation_cfg = CFG_RESET;
   logic        req_taken = 1'b0;
   logic        drain_hold = 1'b0;
   int          send_idle_pct = 9;
   int          recv_idle_pct = 64;
   int          mismatch_count = 0;

   axis_rotate_and_plot_point_top uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // one rotated component, rounded to nearest (ties up) and saturated
   function automatic longint rotate_component(input longint v, input longint crs,
                                               input longint n, input longint dot,
                                               input arp_cfg_type c);
      longint cs, sn, omc, total, r;
      cs    = longint'(c.cos_angle);
      sn    = longint'(c.sin_angle);
      omc   = 64'sd32768 - cs;
      total = v * cs * 64'sd32768 + crs * sn + ((n * dot * omc) >>> 15);
      r     = (total + (64'sd1 <<< 29)) >>> 30;
      if (r > longint'(COORD_MAX)) r = longint'(COORD_MAX);
      if (r < longint'(COORD_MIN)) r = longint'(COORD_MIN);
      return r;
   endfunction

   function automatic arp_rsp_type rotate_and_plot(input arp_req_type p, input arp_cfg_type c);
      longint vx, vy, vz, nx, ny, nz, dot, cx, cy, cz, rx, ry, rz, px, py, wfull;
      arp_rsp_type r;
      vx  = longint'(p.point_x);
      vy  = longint'(p.point_y);
      vz  = longint'(p.point_z);
      nx  = longint'(c.axis_x);
      ny  = longint'(c.axis_y);
      nz  = longint'(c.axis_z);
      dot = nx * vx + ny * vy + nz * vz;
      cx  = ny * vz - nz * vy;
      cy  = nz * vx - nx * vz;
      cz  = nx * vy - ny * vx;
      rx  = rotate_component(vx, cx, nx, dot, c);
      ry  = rotate_component(vy, cy, ny, dot, c);
      rz  = rotate_component(vz, cz, nz, dot, c);
      // signed division truncates toward zero
      px  = (64'sd3 * rx) / 64'sd512 + longint'(X_OFFSET);
      py  = ry / 64'sd128 + longint'(Y_OFFSET);
      r   = '0;
      r.rotated_x = rx[COORD_W-1:0];
      r.rotated_y = ry[COORD_W-1:0];
      r.rotated_z = rz[COORD_W-1:0];
      if (px >= 64'sd0 && px < longint'(SCREEN_WIDTH) &&
          py >= 64'sd0 && py < longint'(SCREEN_LINES)) begin
         wfull        = px / longint'(PIXELS_PER_WORD) + py * longint'(WORDS_PER_LINE);
         r.pixel_word = wfull[WORD_W-1:0];
         r.pixel_mask = MASK_MSB >> (px % longint'(PIXELS_PER_WORD));
         r.on_screen  = 1'b1;
      end
      return r;
   endfunction

   task automatic report_mismatch(input string msg);
      if (mismatch_count < MAX_REPORTS) $display("mismatch at %0t ns: %s", $time, msg);
      mismatch_count++;
   endtask

   // item driver: holds valid until taken, random gaps, occasional drain of the pipe
   always @(negedge clock) begin
      if (!reset && (!req_valid || req_taken)) begin
         if (drain_hold && plots_due.size() == 0) drain_hold = 1'b0;
         else if (!drain_hold && $urandom_range(399) == 0) drain_hold = 1'b1;
         if (!drain_hold && points_pending.size() != 0 &&
             $urandom_range(99) >= send_idle_pct) begin
            req_data  <= points_pending.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      rsp_ready <= !reset && ($urandom_range(99) >= recv_idle_pct);
   end

   // monitor and scoreboard
   always @(posedge clock) begin : scoreboard
      arp_rsp_type want;
      req_taken <= req_valid && req_ready;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (plots_due.size() == 0) begin
               report_mismatch("result with no item outstanding");
            end else begin
               want = plots_due.pop_front();
               if (rsp_data.rotated_x !== want.rotated_x)
                  report_mismatch($sformatf("rotated_x got %0d want %0d",
                     $signed(rsp_data.rotated_x), $signed(want.rotated_x)));
               if (rsp_data.rotated_y !== want.rotated_y)
                  report_mismatch($sformatf("rotated_y got %0d want %0d",
                     $signed(rsp_data.rotated_y), $signed(want.rotated_y)));
               if (rsp_data.rotated_z !== want.rotated_z)
                  report_mismatch($sformatf("rotated_z got %0d want %0d",
                     $signed(rsp_data.rotated_z), $signed(want.rotated_z)));
               if (rsp_data.pixel_word !== want.pixel_word)
                  report_mismatch($sformatf("pixel_word got %0d want %0d",
                     rsp_data.pixel_word, want.pixel_word));
               if (rsp_data.pixel_mask !== want.pixel_mask)
                  report_mismatch($sformatf("pixel_mask got %h want %h",
                     rsp_data.pixel_mask, want.pixel_mask));
               if (rsp_data.on_screen !== want.on_screen)
                  report_mismatch($sformatf("on_screen got %b want %b",
                     rsp_data.on_screen, want.on_screen));
            end
         end
         if (req_valid && req_ready) plots_due.push_back(rotate_and_plot(req_data, rotation_cfg));
         if (csr_we) begin
            case (csr_index)
               CSR_AXIS_X:    rotation_cfg.axis_x    = csr_wdata;
               CSR_AXIS_Y:    rotation_cfg.axis_y    = csr_wdata;
               CSR_AXIS_Z:    rotation_cfg.axis_z    = csr_wdata;
               CSR_COS_ANGLE: rotation_cfg.cos_angle = csr_wdata;
               CSR_SIN_ANGLE: rotation_cfg.sin_angle = csr_wdata;
               default: begin
               end
            endcase
         end
      end
   end

   task automatic push_point(input logic [15:0] x, input logic [15:0] y, input logic [15:0] z);
      arp_req_type p;
      p.point_x = x;
      p.point_y = y;
      p.point_z = z;
      points_pending.push_back(p);
   endtask

   // raises or keeps csr_we; the caller lowers it once the burst is done
   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
   endtask

   task automatic apply_cfg(input arp_cfg_type c);
      csr_write(CSR_AXIS_X, c.axis_x);
      csr_write(CSR_AXIS_Y, c.axis_y);
      csr_write(CSR_AXIS_Z, c.axis_z);
      csr_write(CSR_COS_ANGLE, c.cos_angle);
      csr_write(CSR_SIN_ANGLE, c.sin_angle);
      // index past the register list must leave everything alone
      csr_write(CSR_IDX_W'($urandom_range(5, 7)), CFG_W'($urandom));
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic wait_idle();
      while (points_pending.size() != 0 || req_valid || plots_due.size() != 0)
         @(posedge clock);
      repeat (PIPE_DEPTH + 2) @(posedge clock);
   endtask

   initial begin
      arp_cfg_type c;
      arp_req_type p;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset configuration: field extremes and unit steps
      push_point(16'h0000, 16'h0000, 16'h0000);
      push_point(16'h7fff, 16'h7fff, 16'h7fff);
      push_point(16'h8000, 16'h8000, 16'h8000);
      push_point(16'h7fff, 16'h8000, 16'h0000);
      push_point(16'h8000, 16'h7fff, 16'h0000);
      push_point(16'h0100, 16'h0000, 16'h0000);
      push_point(16'h0000, 16'h0100, 16'h0000);
      push_point(16'h0000, 16'h0000, 16'h0100);
      push_point(16'hff00, 16'hff00, 16'hff00);
      push_point(16'h0001, 16'hffff, 16'h0001);
      push_point(16'h5555, 16'haaaa, 16'h0f0f);
      push_point(16'h7fff, 16'h0000, 16'h8000);
      wait_idle();

      // non-unit axis and angle: saturation and off-screen plots
      apply_cfg('{axis_x: 16'h8000, axis_y: 16'h8000, axis_z: 16'h8000,
                  cos_angle: 16'h8000, sin_angle: 16'h8000});
      push_point(16'h7fff, 16'h7fff, 16'h7fff);
      push_point(16'h8000, 16'h8000, 16'h8000);
      push_point(16'h0100, 16'h0100, 16'h0100);
      push_point(16'h0000, 16'h0000, 16'h0000);
      push_point(16'h7fff, 16'h8000, 16'h7fff);
      wait_idle();
      apply_cfg('{axis_x: 16'h7fff, axis_y: 16'h7fff, axis_z: 16'h7fff,
                  cos_angle: 16'h7fff, sin_angle: 16'h7fff});
      push_point(16'h7fff, 16'h7fff, 16'h7fff);
      push_point(16'h8000, 16'h0001, 16'h7fff);
      push_point(16'hc000, 16'h4000, 16'h2000);

      for (int ph = 0; ph < RAND_PHASES; ph++) begin
         wait_idle();
         if (ph < 3) begin
            send_idle_pct = 9;
            recv_idle_pct = 64;
         end else if (ph < 6) begin
            send_idle_pct = 64;
            recv_idle_pct = 9;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         case (ph)
            0: c = CFG_RESET;
            1: c = '{axis_x: 16'h0000, axis_y: 16'h0000, axis_z: 16'h7fff,
                     cos_angle: 16'sd23170, sin_angle: 16'sd23170};
            2: c = '{axis_x: 16'sd18919, axis_y: 16'sd18919, axis_z: 16'sd18919,
                     cos_angle: 16'h0000, sin_angle: 16'h7fff};
            3: c = '{axis_x: 16'h7fff, axis_y: 16'h0000, axis_z: 16'h0000,
                     cos_angle: 16'h8000, sin_angle: 16'h0000};
            4: c = '{axis_x: 16'h0000, axis_y: 16'h0000, axis_z: 16'h0000,
                     cos_angle: 16'h7fff, sin_angle: 16'h8000};
            default: begin
               c.axis_x    = CFG_W'($urandom);
               c.axis_y    = CFG_W'($urandom);
               c.axis_z    = CFG_W'($urandom);
               c.cos_angle = CFG_W'($urandom);
               c.sin_angle = CFG_W'($urandom);
            end
         endcase
         apply_cfg(c);
         repeat (ITEMS_PER_PHASE) begin
            if ($urandom_range(99) < 70) begin
               p.point_x = COORD_W'($urandom);
               p.point_y = COORD_W'($urandom);
               p.point_z = COORD_W'($urandom);
            end else begin
               // small coordinates keep most plots on screen
               p.point_x = COORD_W'($urandom_range(2047) - 1024);
               p.point_y = COORD_W'($urandom_range(2047) - 1024);
               p.point_z = COORD_W'($urandom_range(2047) - 1024);
            end
            points_pending.push_back(p);
         end
      end
      wait_idle();

      if (mismatch_count == 0) begin
         $display("** axis_rotate_and_plot_point_top: PASSED **");
      end else begin
         $display("** axis_rotate_and_plot_point_top: FAILED **");
      end
      $finish;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("timeout with %0d items still outstanding", plots_due.size());
      $display("** axis_rotate_and_plot_point_top: FAILED **");
      $finish;
   end

endmodule
